/* rtl/sops_pkg.sv */
package sops_pkg;

    localparam int LEN_W   = 7;
    localparam int IDX_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 64;
    localparam int QDEPTH  = 2;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCW     = $clog2(QDEPTH + 1);

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic              is_search;
        logic              wr_ok;
        logic [IDX_W-1:0]  index;
        logic [BYTE_W-1:0] data;
        logic              start;
        logic [POS_W-1:0]  offset;
    } t_op;

endpackage

/* rtl/sops_if.sv */
interface sops_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [sops_pkg::IDX_W-1:0]  pattern_index;
    logic [sops_pkg::BYTE_W-1:0] data_byte;
    logic                        chunk_first;
    logic [sops_pkg::POS_W-1:0]  chunk_base;

    modport source (output valid, command, pattern_index, data_byte, chunk_first,
                    chunk_base, input ready);
    modport sink   (input valid, command, pattern_index, data_byte, chunk_first,
                    chunk_base, output ready);
endinterface

interface sops_out_if;
    logic                       valid;
    logic                       ready;
    logic                       match_found;
    logic [sops_pkg::POS_W-1:0] match_position;

    modport source (output valid, match_found, match_position, input ready);
    modport sink   (input valid, match_found, match_position, output ready);
endinterface

interface sops_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [sops_pkg::LEN_W-1:0] pattern_length;

    modport source (output valid, pattern_length, input ready);
    modport sink   (input valid, pattern_length, output ready);
endinterface

/* rtl/shift_or_pattern_search_unit.sv */
// Shift-or exact pattern search unit.
// Requests arrive on i_in. A load request (command 0) writes data_byte into
// pattern position pattern_index; a search request (command 1) feeds one text
// byte. Every request yields exactly one result on o_out: loads return zeros,
// searches return match_found and the stream position where the match begins.
// Set chunk_first on the first byte of a buffer to restart the match vector
// and load chunk_base as the stream position of that byte.
// i_cfg writes pattern_length; write it only while no request is in flight.
// Throughput is one request per cycle while o_out accepts results; the whole
// per-byte update (all pattern compares, shift and OR) is combinational in the back end.
// A result passes through a queue entry, then the result register, to o_out.
// A two-entry queue separates the front from the back: when o_out stalls the
// result register holds, the queue fills, and i_in.ready drops after two
// further requests. Reset empties the queue and output, sets the match vector
// to all ones, the position to zero and the pattern length to one. The
// pattern store is not cleared and must be loaded before it is searched.
module shift_or_pattern_search_unit #(
    parameter int PATTERN_MAX = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sops_in_if.sink    i_in,
    sops_cfg_if.sink   i_cfg,
    sops_out_if.source o_out
);

    logic          push_valid;
    logic          push_ready;
    sops_pkg::t_op push_op;
    logic          op_valid;
    logic          op_ready;
    sops_pkg::t_op op;

    sops_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_op    (push_op)
    );

    sops_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_op    (push_op),
        .o_pop_valid  (op_valid),
        .i_pop_ready  (op_ready),
        .o_pop_op     (op)
    );

    sops_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .o_op_ready (op_ready),
        .i_op       (op),
        .i_cfg      (i_cfg),
        .o_out      (o_out)
    );

endmodule

/* rtl/sops_front.sv */
module sops_front #(
    parameter int PATTERN_MAX = 64
) (
    sops_in_if.sink        i_in,
    output logic           o_push_valid,
    input  logic           i_push_ready,
    output sops_pkg::t_op  o_push_op
);

    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;

    always_comb begin
        o_push_op.is_search = (i_in.command == sops_pkg::CMD_SEARCH);
        // Loads beyond the store depth still return a result, but the back skips the write.
        o_push_op.wr_ok     = (i_in.command == sops_pkg::CMD_LOAD) &&
                              (32'(i_in.pattern_index) < 32'(PATTERN_MAX));
        o_push_op.index     = i_in.pattern_index;
        o_push_op.data      = i_in.data_byte;
        o_push_op.start     = (i_in.command == sops_pkg::CMD_SEARCH) && i_in.chunk_first;
        o_push_op.offset    = i_in.chunk_base;
    end

endmodule

/* rtl/sops_queue.sv */
module sops_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  sops_pkg::t_op  i_push_op,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output sops_pkg::t_op  o_pop_op
);

    sops_pkg::t_op                 r_mem [sops_pkg::QDEPTH];
    logic [sops_pkg::QAW-1:0]      r_wr_ptr;
    logic [sops_pkg::QAW-1:0]      r_rd_ptr;
    logic [sops_pkg::QCW-1:0]      r_count;
    logic                          push;
    logic                          pop;

    assign o_push_ready = (r_count != sops_pkg::QCW'(sops_pkg::QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_op     = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

endmodule

/* rtl/sops_back.sv */
module sops_back #(
    parameter int PATTERN_MAX = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_op_valid,
    output logic           o_op_ready,
    input  sops_pkg::t_op  i_op,
    sops_cfg_if.sink       i_cfg,
    sops_out_if.source     o_out
);

    localparam int EW = ($clog2(PATTERN_MAX + 1) > sops_pkg::LEN_W) ?
                        $clog2(PATTERN_MAX + 1) : sops_pkg::LEN_W;
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [sops_pkg::BYTE_W-1:0] r_store [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]      r_vec;
    logic [sops_pkg::POS_W-1:0]  r_pos;
    logic [sops_pkg::LEN_W-1:0]  r_len;
    logic                        r_out_valid;
    logic                        r_found;
    logic [sops_pkg::POS_W-1:0]  r_mpos;

    logic                        pop;
    logic [EW-1:0]               eff;
    logic [IW-1:0]               sel;
    logic [PATTERN_MAX-1:0]      base_vec;
    logic [sops_pkg::POS_W-1:0]  base_pos;
    logic [PATTERN_MAX-1:0]      mism;
    logic [PATTERN_MAX-1:0]      n_vec;
    logic [sops_pkg::POS_W-1:0]  n_pos;
    logic                        n_found;
    logic [sops_pkg::POS_W-1:0]  n_mpos;

    assign o_op_ready = !r_out_valid || o_out.ready;
    assign pop        = i_op_valid && o_op_ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid          = r_out_valid;
    assign o_out.match_found    = r_found;
    assign o_out.match_position = r_mpos;

    // A length of zero behaves as one; anything above the store depth is capped.
    always_comb begin
        if (r_len == '0) begin
            eff = EW'(1);
        end else if (EW'(r_len) > EW'(PATTERN_MAX)) begin
            eff = EW'(PATTERN_MAX);
        end else begin
            eff = EW'(r_len);
        end
        sel = IW'(eff - EW'(1));
    end

    always_comb begin
        base_vec = i_op.start ? '1 : r_vec;
        base_pos = i_op.start ? i_op.offset : r_pos;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            mism[i] = (EW'(i) >= eff) || (r_store[i] != i_op.data);
        end
        n_vec = (base_vec << 1) | mism;
        n_pos = base_pos + 64'd1;
        if (i_op.is_search && !n_vec[sel]) begin
            n_found = 1'b1;
            n_mpos  = base_pos - 64'(eff) + 64'd1;
        end else begin
            n_found = 1'b0;
            n_mpos  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec       <= '1;
            r_pos       <= '0;
            r_len       <= sops_pkg::LEN_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_len <= i_cfg.pattern_length;
            end
            if (pop && i_op.is_search) begin
                r_vec <= n_vec;
                r_pos <= n_pos;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_found <= n_found;
            r_mpos  <= n_mpos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_op.wr_ok) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
                if (32'(i_op.index) == 32'(i)) begin
                    r_store[i] <= i_op.data;
                end
            end
        end
    end

    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_found |-> r_mpos == '0)
        else $error("match position not zero without a match");

    a_load_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !i_op.is_search |=> !r_found)
        else $error("load request produced a match");

    a_start_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_op.is_search && i_op.start |=> r_pos == $past(i_op.offset) + 64'd1)
        else $error("position not reloaded at buffer start");

    a_load_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !i_op.is_search && !i_cfg.valid |=> $stable(r_vec) && $stable(r_pos))
        else $error("load request changed search state");

endmodule
